### rtl/ertr3d_pkg.sv
// ---------------------------------------------------------------------------
// ertr3d_pkg
// shared types and constants of the euler rotate and translate unit
// ---------------------------------------------------------------------------
package ertr3d_pkg;

    localparam int STEPS = 20;

    // angle in Q9.16 degrees, one guard bit for reduction
    localparam int ANG_W  = 27;
    // cordic x and y, Q30
    localparam int CXY_W  = 34;
    // cordic residual angle, units of 2^-24 degree
    localparam int CZ_W   = 35;
    // coordinate inside the rotation chain, Q16.16 with growth
    localparam int CRD_W  = 36;
    // product of a coordinate and a coefficient
    localparam int PROD_W = 70;

    localparam logic signed [ANG_W-1:0] FULL_TURN    = 27'sd23592960;
    localparam logic signed [ANG_W-1:0] HALF_TURN    = 27'sd11796480;
    localparam logic signed [ANG_W-1:0] QUARTER_TURN = 27'sd5898240;
    localparam logic signed [CXY_W-1:0] CORDIC_GAIN  = 34'sd652032874;

    // atan(2^-i) in units of 2^-24 degree
    localparam logic signed [31:0] ATAN_TAB [STEPS] = '{
        32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
        32'sd60000935,  32'sd30029717,  32'sd15018523,  32'sd7509720,
        32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
        32'sd234684,    32'sd117342,    32'sd58671,     32'sd29336,
        32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833
    };

    // depth of the sine/cosine pipeline in stages: reduction stage plus one per step
    localparam int CORDIC_LAT = STEPS + 1;

    typedef logic signed [CXY_W-1:0]  t_coef;
    typedef logic signed [CRD_W-1:0]  t_crd;
    typedef logic signed [PROD_W-1:0] t_prod;

    typedef struct packed {
        t_coef sin_v;
        t_coef cos_v;
    } t_sincos;

    // round a Q46 sum to Q16, halves upward
    function automatic t_crd rnd30(input t_prod v);
        t_prod s;
        s = (v + t_prod'(64'sd536870912)) >>> 30;
        return s[CRD_W-1:0];
    endfunction

endpackage

### rtl/euler_rotate_translate_3d_unit.sv
// ---------------------------------------------------------------------------
// euler_rotate_translate_3d_unit
// rotates a point by roll, pitch and heading and adds a translation
// ---------------------------------------------------------------------------
// One input word carries a Q16.16 point, a Q16.16 translation and three
// Q9.16 degree angles; one output word carries the transformed, saturated
// point. A word is taken in every cycle in which the pipeline advances; it
// passes through the 21-stage sine/cosine pipeline (angle reduction plus
// 20 cordic steps), then the coefficient stage, three multiply/round stage
// pairs and the translate/saturate stage. The whole
// pipeline advances whenever the output register is empty or being taken,
// so a stall on the output side holds every word in place.
module euler_rotate_translate_3d_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // point_x, point_y, point_z, shift_x, shift_y, shift_z (32 each),
    // heading_deg, pitch_deg, roll_deg (26 each), 2 zero pad bits
    input  logic [271:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // out_x, out_y, out_z (32 each)
    output logic [95:0]  o_m_axis_tdata
);
    import ertr3d_pkg::*;

    // cordic stages, coefficient stage, six rotation stages, saturate stage
    localparam int LAT = CORDIC_LAT + 8;

    logic en;
    logic [LAT-1:0] r_vld;

    // pipeline moves when the output slot is free or being drained
    assign en = i_m_axis_tready || !r_vld[LAT-1];
    assign o_s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_s_axis_tvalid};
        end
    end

    // sine/cosine of each angle; heading and roll take a negated sine
    t_sincos sc_h, sc_p, sc_r;

    ertr3d_cordic u_cordic_h (
        .i_clk(i_clk), .i_en(en), .i_angle(i_s_axis_tdata[217:192]),
        .i_negate_sin(1'b1), .o_sc(sc_h)
    );
    ertr3d_cordic u_cordic_p (
        .i_clk(i_clk), .i_en(en), .i_angle(i_s_axis_tdata[243:218]),
        .i_negate_sin(1'b0), .o_sc(sc_p)
    );
    ertr3d_cordic u_cordic_r (
        .i_clk(i_clk), .i_en(en), .i_angle(i_s_axis_tdata[269:244]),
        .i_negate_sin(1'b1), .o_sc(sc_r)
    );

    // point and translation ride alongside the cordic stages
    logic [191:0] r_dly [0:CORDIC_LAT-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dly[0] <= i_s_axis_tdata[191:0];
            for (int k = 1; k < CORDIC_LAT; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    // translation carried to the end of the rotation chain
    logic signed [31:0] r_tx [0:6];
    logic signed [31:0] r_ty [0:6];
    logic signed [31:0] r_tz [0:6];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tx[0] <= r_dly[CORDIC_LAT-1][127:96];
            r_ty[0] <= r_dly[CORDIC_LAT-1][159:128];
            r_tz[0] <= r_dly[CORDIC_LAT-1][191:160];
            for (int k = 1; k < 7; k++) begin
                r_tx[k] <= r_tx[k-1];
                r_ty[k] <= r_ty[k-1];
                r_tz[k] <= r_tz[k-1];
            end
        end
    end

    // coefficient stage
    t_coef r_sh, r_ch, r_sp, r_cp, r_sr, r_cr;
    t_crd  r_px, r_py, r_pz;

    // roll products, pitch and heading coefficients carried along
    t_prod r_m0, r_m1, r_m2, r_m3;
    t_coef r2_sh, r2_ch, r2_sp, r2_cp;
    t_crd  r2_pz;

    // roll sums
    t_crd  r_x1, r_y1, r3_pz;
    t_coef r3_sh, r3_ch, r3_sp, r3_cp;

    // pitch products
    t_prod r_n0, r_n1, r_n2, r_n3;
    t_crd  r4_x1;
    t_coef r4_sh, r4_ch;

    // pitch sums
    t_crd  r_y2, r_z2, r5_x1;
    t_coef r5_sh, r5_ch;

    // heading products
    t_prod r_h0, r_h1, r_h2, r_h3;
    t_crd  r6_y2;

    // heading sums
    t_crd  r_xo, r_yo, r_zo;

    // output word
    logic [95:0] r_out;

    function automatic logic [31:0] sat32(input t_crd v, input logic signed [31:0] t);
        logic signed [CRD_W:0] s;
        s = (CRD_W+1)'(v) + (CRD_W+1)'(t);
        if (s > (CRD_W+1)'(64'sd2147483647)) begin
            return 32'h7fff_ffff;
        end else if (s < -(CRD_W+1)'(64'sd2147483648)) begin
            return 32'h8000_0000;
        end
        return s[31:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sh <= sc_h.sin_v;
            r_ch <= sc_h.cos_v;
            r_sp <= sc_p.sin_v;
            r_cp <= sc_p.cos_v;
            r_sr <= sc_r.sin_v;
            r_cr <= sc_r.cos_v;
            r_px <= CRD_W'($signed(r_dly[CORDIC_LAT-1][31:0]));
            r_py <= CRD_W'($signed(r_dly[CORDIC_LAT-1][63:32]));
            r_pz <= CRD_W'($signed(r_dly[CORDIC_LAT-1][95:64]));

            // roll about z
            r_m0  <= PROD_W'(r_cr) * PROD_W'(r_px);
            r_m1  <= PROD_W'(r_sr) * PROD_W'(r_py);
            r_m2  <= PROD_W'(r_sr) * PROD_W'(r_px);
            r_m3  <= PROD_W'(r_cr) * PROD_W'(r_py);
            r2_sh <= r_sh;
            r2_ch <= r_ch;
            r2_sp <= r_sp;
            r2_cp <= r_cp;
            r2_pz <= r_pz;

            r_x1  <= rnd30(r_m0 - r_m1);
            r_y1  <= rnd30(r_m2 + r_m3);
            r3_pz <= r2_pz;
            r3_sh <= r2_sh;
            r3_ch <= r2_ch;
            r3_sp <= r2_sp;
            r3_cp <= r2_cp;

            // pitch about x
            r_n0  <= PROD_W'(r3_cp) * PROD_W'(r_y1);
            r_n1  <= PROD_W'(r3_sp) * PROD_W'(r3_pz);
            r_n2  <= PROD_W'(r3_sp) * PROD_W'(r_y1);
            r_n3  <= PROD_W'(r3_cp) * PROD_W'(r3_pz);
            r4_x1 <= r_x1;
            r4_sh <= r3_sh;
            r4_ch <= r3_ch;

            r_y2  <= rnd30(r_n0 - r_n1);
            r_z2  <= rnd30(r_n2 + r_n3);
            r5_x1 <= r4_x1;
            r5_sh <= r4_sh;
            r5_ch <= r4_ch;

            // heading about y
            r_h0  <= PROD_W'(r5_ch) * PROD_W'(r5_x1);
            r_h1  <= PROD_W'(r5_sh) * PROD_W'(r_z2);
            r_h2  <= PROD_W'(r5_ch) * PROD_W'(r_z2);
            r_h3  <= PROD_W'(r5_sh) * PROD_W'(r5_x1);
            r6_y2 <= r_y2;

            r_xo <= rnd30(r_h0 + r_h1);
            r_yo <= r6_y2;
            r_zo <= rnd30(r_h2 - r_h3);

            // translate and saturate
            r_out <= {sat32(r_zo, r_tz[6]), sat32(r_yo, r_ty[6]), sat32(r_xo, r_tx[6])};
        end
    end

    assign o_m_axis_tvalid = r_vld[LAT-1];
    assign o_m_axis_tdata  = r_out;

endmodule

### rtl/ertr3d_cordic.sv
// ---------------------------------------------------------------------------
// ertr3d_cordic
// pipelined sine and cosine of an angle in degrees, one step per stage
// ---------------------------------------------------------------------------
module ertr3d_cordic (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic signed [25:0]     i_angle,
    input  logic                   i_negate_sin,
    output ertr3d_pkg::t_sincos    o_sc
);
    import ertr3d_pkg::*;

    logic signed [CXY_W-1:0] r_x [0:STEPS];
    logic signed [CXY_W-1:0] r_y [0:STEPS];
    logic signed [CZ_W-1:0]  r_z [0:STEPS];
    logic                    r_flip_s [0:STEPS];
    logic                    r_flip_c [0:STEPS];

    logic signed [ANG_W-1:0] a0, a1, a2, a3;
    logic                    fold;

    // reduce to (-180, 180], then fold into [-90, 90]
    always_comb begin
        a0 = ANG_W'(i_angle);
        if (a0 >= FULL_TURN) begin
            a1 = a0 - FULL_TURN;
        end else if (a0 <= -FULL_TURN) begin
            a1 = a0 + FULL_TURN;
        end else begin
            a1 = a0;
        end
        if (a1 > HALF_TURN) begin
            a2 = a1 - FULL_TURN;
        end else if (a1 <= -HALF_TURN) begin
            a2 = a1 + FULL_TURN;
        end else begin
            a2 = a1;
        end
        fold = 1'b0;
        if (a2 > QUARTER_TURN) begin
            a3   = a2 - HALF_TURN;
            fold = 1'b1;
        end else if (a2 < -QUARTER_TURN) begin
            a3   = a2 + HALF_TURN;
            fold = 1'b1;
        end else begin
            a3 = a2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]      <= CORDIC_GAIN;
            r_y[0]      <= '0;
            r_z[0]      <= CZ_W'(a3) <<< 8;
            r_flip_s[0] <= fold ^ i_negate_sin;
            r_flip_c[0] <= fold;
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        logic signed [CXY_W-1:0] dx, dy;
        logic signed [CZ_W-1:0]  da;
        assign dx = r_y[i] >>> i;
        assign dy = r_x[i] >>> i;
        assign da = CZ_W'(ATAN_TAB[i]);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - dx;
                    r_y[i+1] <= r_y[i] + dy;
                    r_z[i+1] <= r_z[i] - da;
                end else begin
                    r_x[i+1] <= r_x[i] + dx;
                    r_y[i+1] <= r_y[i] - dy;
                    r_z[i+1] <= r_z[i] + da;
                end
                r_flip_s[i+1] <= r_flip_s[i];
                r_flip_c[i+1] <= r_flip_c[i];
            end
        end
    end

    assign o_sc.sin_v = r_flip_s[STEPS] ? -r_y[STEPS] : r_y[STEPS];
    assign o_sc.cos_v = r_flip_c[STEPS] ? -r_x[STEPS] : r_x[STEPS];

endmodule
